@@ hdl/audio_echo_comb_assert.svh @@
// Assertion macros for the echo comb block.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef AUDIO_ECHO_COMB_ASSERT_SVH
`define AUDIO_ECHO_COMB_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define AEC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define AEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/aec_pkg.sv @@
package aec_pkg;

  // PCM sample, two's complement
  typedef logic signed [15:0] sample_t;

  // configuration register index
  typedef logic [1:0] cfg_index_t;

  localparam cfg_index_t REG_GAIN  = 2'd0;
  localparam cfg_index_t REG_DELAY = 2'd1;
  localparam cfg_index_t REG_MODE  = 2'd2;

  localparam sample_t    GAIN_RESET  = 16'sd16384;  // 0.5 in Q1.15
  localparam logic [15:0] DELAY_RESET = 16'd1;

  localparam sample_t SAMPLE_MAX = 16'sh7FFF;
  localparam sample_t SAMPLE_MIN = 16'sh8000;

  // Clamp an 18-bit sum into the 16-bit sample range
  function automatic sample_t sat16(input logic signed [17:0] v);
    sample_t r;
    if (v > 18'sd32767) begin
      r = SAMPLE_MAX;
    end else if (v < -18'sd32768) begin
      r = SAMPLE_MIN;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/aec_delay_ram.sv @@
// Simple dual-port delay memory: one write and one registered read per cycle.
// Read during write to the same address returns the old contents.
module aec_delay_ram #(
  parameter int Depth = 32768,
  parameter int AddrW = 15
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [AddrW-1:0]     rd_addr,
  output aec_pkg::sample_t     rd_data,
  input  logic                 wr_en,
  input  logic [AddrW-1:0]     wr_addr,
  input  aec_pkg::sample_t     wr_data
);
  import aec_pkg::*;

  sample_t mem [Depth];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, held while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/audio_echo_comb.sv @@
// Echo comb filter on a stream of 16-bit PCM samples (channels interleaved).
// Input channel: in_valid / in_stall with sample_in. Output channel:
// out_valid / out_stall with sample_out. One output sample per input sample,
// in order. Configuration: cfg_write with cfg_index (0 gain, 1 delay length,
// 2 feedback mode) and cfg_data; write only while the block is idle.
// Pipeline: an accepted sample goes through a three-stage pipe (read,
// multiply, add and write) before it shows on sample_out.
// Throughput: one sample per cycle while in_stall is low. With feedback mode
// on and a delay length of one, the stored value is the previous output; the
// multiply-add loop via the memory holds input while a sample is in stage 1.
// Reset: gain 0.5, delay 1, feedforward mode, cursor at zero. The delay memory
// is not swept: a fill count marks how far it has been written and entries
// beyond it read as zero, so the block takes samples right after reset.
// Stall: a skid register behind the output register catches one result, so
// the block keeps accepting while a result waits; in_stall rises once the skid
// register is occupied (the whole pipe then holds) or in the feedback case.
module audio_echo_comb #(
  parameter int MAX_DELAY = 32768
) (
  input  logic                  clk,
  input  logic                  rst,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  aec_pkg::sample_t      sample_in,
  // output channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output aec_pkg::sample_t      sample_out,
  // configuration
  input  logic                  cfg_write,
  input  aec_pkg::cfg_index_t   cfg_index,
  input  logic [15:0]           cfg_data
);
  import aec_pkg::*;

  localparam int AddrW = $clog2(MAX_DELAY);
  localparam int LenW  = AddrW + 1;
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_DELAY);

  // configuration registers
  sample_t     gain_q15;
  logic [15:0] delay_length;
  logic        feedback_mode;

  // control
  logic [LenW-1:0]  len_eff;
  logic             len_one;
  logic             pipe_en;
  logic             fb_hold;
  logic             accept;
  logic [AddrW-1:0] ring_cursor;
  logic [AddrW-1:0] ring_cursor_next;
  logic [AddrW-1:0] rd_addr;
  logic [LenW-1:0]  cursor_inc;
  logic [LenW-1:0]  fill;

  // stage 1: read data returns
  logic             s1_valid;
  sample_t          s1_dry;
  logic [AddrW-1:0] s1_addr;
  logic             s1_filled;
  sample_t          mem_q;
  sample_t          stored;
  logic signed [31:0] product;

  // stage 2: scale, add, write back
  logic               s2_valid;
  sample_t            s2_dry;
  logic [AddrW-1:0]   s2_addr;
  logic signed [31:0] s2_prod;
  logic signed [31:0] echo_full;
  logic signed [16:0] echo;
  logic signed [17:0] sum_wide;
  sample_t            sum;
  sample_t            wr_data;
  logic               wr_en;

  // last write, for forwarding across the read latency
  logic             last_wr_valid;
  logic [AddrW-1:0] last_wr_addr;
  sample_t          last_wr_data;

  // output register and skid
  logic    out_take;
  logic    skid_valid;
  sample_t skid_data;

  // configuration writes; unknown index is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_q15      <= GAIN_RESET;
      delay_length  <= DELAY_RESET;
      feedback_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GAIN:  gain_q15      <= $signed(cfg_data);
        REG_DELAY: delay_length  <= cfg_data;
        REG_MODE:  feedback_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective ring length: zero acts as one, clamp at memory depth
  always_comb begin
    if (delay_length == 16'd0) begin
      len_eff = LenW'(1);
    end else if (32'(delay_length) > 32'(MAX_DELAY)) begin
      len_eff = MaxLen;
    end else begin
      len_eff = LenW'(delay_length);
    end
  end

  assign len_one = (len_eff == LenW'(1));

  // handshake: pipe holds while the skid register is occupied;
  // feedback at delay one needs a bubble after each sample
  assign pipe_en  = !skid_valid;
  assign fb_hold  = feedback_mode && len_one && s1_valid;
  assign in_stall = skid_valid || fb_hold;
  assign accept   = in_valid && !in_stall;

  // ring cursor: restart if past the end, then step with wrap
  always_comb begin
    rd_addr          = ({1'b0, ring_cursor} >= len_eff) ? '0 : ring_cursor;
    cursor_inc       = {1'b0, rd_addr} + LenW'(1);
    ring_cursor_next = (cursor_inc >= len_eff) ? '0 : cursor_inc[AddrW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_cursor <= '0;
    end else if (accept) begin
      ring_cursor <= ring_cursor_next;
    end
  end

  // delay memory
  aec_delay_ram #(
    .Depth (MAX_DELAY),
    .AddrW (AddrW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (pipe_en),
    .rd_addr (rd_addr),
    .rd_data (mem_q),
    .wr_en   (wr_en),
    .wr_addr (s2_addr),
    .wr_data (wr_data)
  );

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pipe_en) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_dry    <= sample_in;
      s1_addr   <= rd_addr;
      s1_filled <= ({1'b0, rd_addr} < fill);
    end
  end

  // stored sample: newest write to the same entry wins, unwritten reads zero
  always_comb begin
    priority if (s2_valid && !feedback_mode && (s2_addr == s1_addr)) begin
      stored = s2_dry;
    end else if (last_wr_valid && (last_wr_addr == s1_addr)) begin
      stored = last_wr_data;
    end else if (s1_filled) begin
      stored = mem_q;
    end else begin
      stored = '0;
    end
  end

  assign product = 32'(gain_q15) * 32'(stored);

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (pipe_en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s2_dry  <= s1_dry;
      s2_addr <= s1_addr;
      s2_prod <= product;
    end
  end

  // Q1.15 scale truncating toward zero, add, saturate
  always_comb begin
    echo_full = (s2_prod + (s2_prod[31] ? 32'sd32767 : 32'sd0)) >>> 15;
    echo      = echo_full[16:0];
    sum_wide  = $signed({{2{s2_dry[15]}}, s2_dry}) + $signed({echo[16], echo});
    sum       = sat16(sum_wide);
    wr_data   = feedback_mode ? sum : s2_dry;
    wr_en     = pipe_en && s2_valid;
  end

  // last write and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      last_wr_valid <= 1'b0;
      fill          <= '0;
    end else if (pipe_en) begin
      last_wr_valid <= s2_valid;
      if (wr_en && ({1'b0, s2_addr} == fill)) begin
        fill <= fill + LenW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      last_wr_addr <= s2_addr;
      last_wr_data <= wr_data;
    end
  end

  // output register with one-entry skid
  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (wr_en) begin
      if (!out_valid || out_take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        sample_out <= skid_data;
      end
    end else if (wr_en) begin
      if (!out_valid || out_take) begin
        sample_out <= sum;
      end else begin
        skid_data <= sum;
      end
    end
  end

  // checks
  `include "audio_echo_comb_assert.svh"

  `AEC_ASSERT_IMPL(a_skid_behind_out, skid_valid, out_valid && in_stall, "skid without output")
  `AEC_ASSERT_IMPL(a_write_in_order, wr_en, {1'b0, s2_addr} <= fill, "write past fill count")
  `AEC_ASSERT_NEXT(a_fill_bound, 1'b1, fill <= MaxLen, "fill count beyond memory depth")

endmodule
